FILE: rtl/ddt_pkg.sv
// ddt_pkg: shared types and constants for the divided-difference table block
// holds the transfer payload structs, the q16.16 limits and the divider handshake structs
// no dependencies
package ddt_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int Q_W            = 32;
    localparam int FRAC_W         = 16;
    localparam int OUT_IDX_W      = 5;

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    // one input point
    typedef struct packed {
        logic                  start_set;
        logic signed [Q_W-1:0] x_value;
        logic signed [Q_W-1:0] y_value;
    } ddt_in_t;

    // one table entry
    typedef struct packed {
        logic [OUT_IDX_W-1:0]  row_index;
        logic [OUT_IDX_W-1:0]  order;
        logic signed [Q_W-1:0] difference;
        logic                  bad_divisor;
        logic                  last_of_row;
    } ddt_out_t;

    // divider request: numerator and divisor are 33-bit two's complement
    typedef struct packed {
        logic         start;
        logic [Q_W:0] num;
        logic [Q_W:0] den;
    } ddt_div_req_t;

    // divider response: done pulses for one cycle with quotient and flag
    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quot;
        logic           bad;
    } ddt_div_rsp_t;

endpackage

FILE: rtl/ddt_divider.sv
// ddt_divider: iterative q16.16 divider, (num * 2^16) / den, truncated toward zero
// radix-2 restoring, one quotient bit per cycle, saturates and flags on overflow or zero divisor
// depends on ddt_pkg
module ddt_divider (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ddt_pkg::ddt_div_req_t div_req,
    output ddt_pkg::ddt_div_rsp_t div_rsp
);
    import ddt_pkg::*;

    localparam int CNT_W = $clog2(Q_W);
    localparam int DVD_W = Q_W + FRAC_W;

    typedef enum logic [2:0] {D_IDLE, D_CHECK, D_RUN, D_FIN, D_DONE} div_state_t;

    div_state_t       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [Q_W-1:0]   num_mag_reg;
    logic [Q_W-1:0]   den_mag_reg;
    logic             num_neg_reg;
    logic             neg_reg;
    logic [Q_W-1:0]   rem_reg;
    logic [Q_W-1:0]   quo_reg;
    logic [Q_W-1:0]   result_reg;
    logic             bad_reg;

    logic [Q_W:0]     num_abs;
    logic [Q_W:0]     den_abs;
    logic [Q_W:0]     rem_sh;
    logic [Q_W+1:0]   trial;
    logic             ovf;

    // operand magnitudes
    assign num_abs = div_req.num[Q_W] ? (~div_req.num + 1'b1) : div_req.num;
    assign den_abs = div_req.den[Q_W] ? (~div_req.den + 1'b1) : div_req.den;

    // quotient of 2^32 or more iff |num| >= |den| * 2^16
    assign ovf = {{FRAC_W{1'b0}}, num_mag_reg} >= DVD_W'({den_mag_reg, {FRAC_W{1'b0}}});

    // one restoring step
    assign rem_sh = {rem_reg, quo_reg[Q_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_mag_reg};

    // sequencer, working registers and registered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            case (state_reg)
                D_IDLE: begin
                    if (div_req.start) begin
                        num_mag_reg <= num_abs[Q_W-1:0];
                        den_mag_reg <= den_abs[Q_W-1:0];
                        num_neg_reg <= div_req.num[Q_W];
                        neg_reg     <= div_req.num[Q_W] ^ div_req.den[Q_W];
                        state_reg   <= D_CHECK;
                    end
                end
                D_CHECK: begin
                    if (den_mag_reg == '0) begin
                        // repeated abscissa
                        bad_reg <= 1'b1;
                        if (num_mag_reg == '0) begin
                            result_reg <= '0;
                        end else begin
                            result_reg <= num_neg_reg ? Q_MIN : Q_MAX;
                        end
                        state_reg <= D_DONE;
                    end else if (ovf) begin
                        bad_reg    <= 1'b1;
                        result_reg <= neg_reg ? Q_MIN : Q_MAX;
                        state_reg  <= D_DONE;
                    end else begin
                        rem_reg   <= {{FRAC_W{1'b0}}, num_mag_reg[Q_W-1:FRAC_W]};
                        quo_reg   <= {num_mag_reg[FRAC_W-1:0], {FRAC_W{1'b0}}};
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (!trial[Q_W+1]) begin
                        rem_reg <= trial[Q_W-1:0];
                        quo_reg <= {quo_reg[Q_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[Q_W-1:0];
                        quo_reg <= {quo_reg[Q_W-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(Q_W - 1)) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    // apply sign and clamp to the q16.16 range
                    if (neg_reg) begin
                        if (quo_reg > Q_MIN) begin
                            result_reg <= Q_MIN;
                            bad_reg    <= 1'b1;
                        end else begin
                            result_reg <= ~quo_reg + 1'b1;
                            bad_reg    <= 1'b0;
                        end
                    end else begin
                        if (quo_reg[Q_W-1]) begin
                            result_reg <= Q_MAX;
                            bad_reg    <= 1'b1;
                        end else begin
                            result_reg <= quo_reg;
                            bad_reg    <= 1'b0;
                        end
                    end
                    state_reg <= D_DONE;
                end
                D_DONE: begin
                    state_reg <= D_IDLE;
                end
                default: begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign div_rsp.done = (state_reg == D_DONE);
    assign div_rsp.quot = result_reg;
    assign div_rsp.bad  = bad_reg;

endmodule

FILE: rtl/divided_difference_table.sv
// divided_difference_table: top level, point sequencer, point memories and result register
// depends on ddt_pkg and ddt_divider
//
// Takes one interpolation point (x, y in signed q16.16) per input transfer and
// emits row k of Newton's divided-difference table, orders 0..k, one result
// transfer per order, with last_of_row on order k. start_set begins a new set;
// a point that arrives on a full set (MAX_POINTS points) without start_set is
// taken and dropped with no results. The block takes no new point until the
// last entry of the row has moved into the result register. Every order above
// zero goes through one shared radix-2 divider that produces one quotient bit
// per cycle in its 32-step loop; each entry passes an emit step, an operand
// step and a full division, and the emit step waits while the result register
// holds an entry the result side has not taken. A zero divisor or a quotient
// out of the q16.16 range returns the saturated value (zero for 0/0) with
// bad_divisor set.
module divided_difference_table #(
    parameter int MAX_POINTS = ddt_pkg::MAX_POINTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ddt_pkg::ddt_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output ddt_pkg::ddt_out_t m_item
);
    import ddt_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_EMIT, S_DIV_START, S_DIV_WAIT} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] j_reg;
    logic [Q_W-1:0]   x_reg;
    logic [Q_W-1:0]   cur_reg;
    logic             bad_reg;
    logic             m_valid_reg;
    ddt_out_t         m_item_reg;

    logic [Q_W-1:0]   x_mem [MAX_POINTS];
    logic [Q_W-1:0]   prev_mem [MAX_POINTS];
    logic [Q_W-1:0]   x_rd_reg;
    logic [Q_W-1:0]   prev_rd_reg;

    logic             in_fire;
    logic             set_full;
    logic             take_point;
    logic [IDX_W-1:0] k_new;
    logic             emit_fire;
    logic [IDX_W-1:0] x_raddr;

    ddt_div_req_t     div_req;
    ddt_div_rsp_t     div_rsp;

    // input transfer and row setup
    assign s_ready    = (state_reg == S_IDLE);
    assign in_fire    = s_valid && s_ready;
    assign set_full   = !s_item.start_set && (count_reg == CNT_W'(MAX_POINTS));
    assign take_point = in_fire && !set_full;
    assign k_new      = s_item.start_set ? '0 : count_reg[IDX_W-1:0];

    // an entry leaves when the result register is free
    assign emit_fire = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign x_raddr   = k_reg - j_reg - 1'b1;

    // abscissa store, read of x_{k-j} for the next order
    always_ff @(posedge aclk) begin
        if (take_point) begin
            x_mem[k_new] <= s_item.x_value;
        end
        if (emit_fire) begin
            x_rd_reg <= x_mem[x_raddr];
        end
    end

    // previous row store, read-first so the old entry feeds the next order
    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            prev_rd_reg     <= prev_mem[j_reg];
            prev_mem[j_reg] <= cur_reg;
        end
    end

    // divider operands: row[j-1] - prev[j-1] over x_k - x_{k-j}
    assign div_req.start = (state_reg == S_DIV_START);
    assign div_req.num   = {cur_reg[Q_W-1], cur_reg} - {prev_rd_reg[Q_W-1], prev_rd_reg};
    assign div_req.den   = {x_reg[Q_W-1], x_reg} - {x_rd_reg[Q_W-1], x_rd_reg};

    ddt_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // row sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !emit_fire) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (take_point) begin
                        k_reg     <= k_new;
                        j_reg     <= '0;
                        x_reg     <= s_item.x_value;
                        cur_reg   <= s_item.y_value;
                        bad_reg   <= 1'b0;
                        count_reg <= CNT_W'(k_new) + 1'b1;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        m_valid_reg            <= 1'b1;
                        m_item_reg.row_index   <= OUT_IDX_W'(k_reg);
                        m_item_reg.order       <= OUT_IDX_W'(j_reg);
                        m_item_reg.difference  <= cur_reg;
                        m_item_reg.bad_divisor <= bad_reg;
                        m_item_reg.last_of_row <= (j_reg == k_reg);
                        if (j_reg == k_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                S_DIV_START: begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        cur_reg   <= div_rsp.quot;
                        bad_reg   <= div_rsp.bad;
                        state_reg <= S_EMIT;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // a quotient only comes back while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    // the order never passes the row index while a row is in progress
    a_order_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (j_reg <= k_reg))
        else $error("order ran past the row index");

    // a new set always restarts at one stored point
    a_set_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_item.start_set) |=> (count_reg == CNT_W'(1)))
        else $error("start of set did not reset the point count");

    // the point count stays within the store
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond capacity");

endmodule
